/* rtl/npc_pkg.sv */
// shared types and constants for the nearest palette color match block
package npc_pkg;

    // default palette depth
    localparam int PALETTE_ENTRIES_DEF = 256;

    // transparent entry and alpha byte of a loaded word
    localparam logic [7:0] TRANSPARENT_ENTRY = 8'hFF;
    localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;

    // squared distance width: 3 * 255 * 255 fits in 18 bits
    localparam int          DIST_W   = 18;
    localparam logic [17:0] DIST_MAX = '1;

    // item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } npc_state_t;

    // palette entry beat into the distance unit
    typedef struct packed {
        logic       live;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_beat_t;

    // distance beat out of the distance unit
    typedef struct packed {
        logic              live;
        logic [7:0]        idx;
        logic [DIST_W-1:0] sq_dist;
    } dist_beat_t;

endpackage

/* rtl/npc_dist_unit.sv */
// squared euclidean distance unit, one palette entry per cycle
module npc_dist_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  npc_pkg::entry_beat_t entry,
    input  logic [7:0]          q_red,
    input  logic [7:0]          q_green,
    input  logic [7:0]          q_blue,
    output npc_pkg::dist_beat_t  result
);
    import npc_pkg::*;

    logic [7:0]  diff_r, diff_g, diff_b;
    logic [15:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [7:0]  idx_reg;
    logic        live_reg;

    // absolute channel differences
    always_comb
    begin
        diff_r = (q_red   >= entry.red)   ? (q_red   - entry.red)   : (entry.red   - q_red);
        diff_g = (q_green >= entry.green) ? (q_green - entry.green) : (entry.green - q_green);
        diff_b = (q_blue  >= entry.blue)  ? (q_blue  - entry.blue)  : (entry.blue  - q_blue);
    end

    // registered squares
    always_ff @(posedge clk)
    begin
        sq_r_reg <= 16'(diff_r) * 16'(diff_r);
        sq_g_reg <= 16'(diff_g) * 16'(diff_g);
        sq_b_reg <= 16'(diff_b) * 16'(diff_b);
        idx_reg  <= entry.idx;
    end

    // beat tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b0;
        else
            live_reg <= entry.live;
    end

    // sum of squares
    always_comb
    begin
        result.live    = live_reg;
        result.idx     = idx_reg;
        result.sq_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

endmodule

/* rtl/nearest_palette_color_match.sv */
// top level: palette store, scan sequencer and result register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall    | action, entry_index, red/green/blue_in,
//          |           |                        | color_555
//  out     | source    | out_valid / out_stall  | best_index, packed_word
//
// a load goes straight from accept to the done state; a query scans every palette entry
// through the registered read of the single read port of the palette memory, giving one
// entry per cycle to the shared distance unit, and drains it before the done state.
// in_stall is high from accept until the result has moved to the output register; a result
// waiting on out_stall does not block the next accept.
// reset clears one valid flop per entry at once, so no clearing pass is needed.
module nearest_palette_color_match #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [14:0] color_555,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  best_index,
    output logic [31:0] packed_word
);
    import npc_pkg::*;

    localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    npc_state_t state_reg, state_next;

    // palette memory and per-entry valid flags
    logic [23:0] mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;
    logic [23:0] rd_data_reg;
    logic        rd_vld_reg;
    logic        rd_live_reg;
    logic [7:0]  rd_idx_reg;

    logic [IW-1:0] cnt_reg;
    logic [7:0]    q_red_reg, q_green_reg, q_blue_reg;
    logic [7:0]    best_idx_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [31:0]   res_word_reg;

    logic        out_valid_reg;
    logic [7:0]  best_index_reg;
    logic [31:0] packed_word_reg;

    logic        accept;
    logic        mem_we;
    logic        scan_rd;
    logic        out_load;
    logic [23:0] load_rgb;
    logic [31:0] load_word;
    logic        in_range;
    logic        last_addr;

    entry_beat_t entry;
    dist_beat_t  dist_beat;

    // load word forming
    always_comb
    begin
        load_rgb  = {blue_in, green_in, red_in};
        load_word = {ALPHA_OPAQUE, load_rgb};
        if (entry_index == TRANSPARENT_ENTRY)
        begin
            load_rgb  = '0;
            load_word = '0;
        end
        in_range  = (32'(entry_index) < PALETTE_ENTRIES);
        last_addr = (cnt_reg == IW'(PALETTE_ENTRIES - 1));
    end

    // sequencer next state and controls
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        accept     = 1'b0;
        mem_we     = 1'b0;
        scan_rd    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    accept = 1'b1;
                    if (action == ACT_LOAD)
                    begin
                        mem_we     = in_range;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_rd = 1'b1;
                if (last_addr)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!rd_live_reg && !dist_beat.live)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // palette memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[entry_index[IW-1:0]] <= load_rgb;
        rd_data_reg <= mem[cnt_reg];
    end

    // valid flags, read beat tracking and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_live_reg <= 1'b0;
            rd_idx_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (mem_we)
                vld_reg[entry_index[IW-1:0]] <= 1'b1;
            rd_vld_reg  <= vld_reg[cnt_reg];
            rd_live_reg <= scan_rd;
            rd_idx_reg  <= 8'(cnt_reg);
            if (accept)
                cnt_reg <= '0;
            else if (scan_rd)
                cnt_reg <= cnt_reg + IW'(1);
        end
    end

    // entry beat: never-written entries read as black
    always_comb
    begin
        entry.live  = rd_live_reg;
        entry.idx   = rd_idx_reg;
        entry.red   = rd_vld_reg ? rd_data_reg[7:0]   : 8'd0;
        entry.green = rd_vld_reg ? rd_data_reg[15:8]  : 8'd0;
        entry.blue  = rd_vld_reg ? rd_data_reg[23:16] : 8'd0;
    end

    npc_dist_unit u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (entry),
        .q_red   (q_red_reg),
        .q_green (q_green_reg),
        .q_blue  (q_blue_reg),
        .result  (dist_beat)
    );

    // query capture and running minimum, lowest index wins ties
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_red_reg    <= {color_555[4:0],   3'b100};
            q_green_reg  <= {color_555[9:5],   3'b100};
            q_blue_reg   <= {color_555[14:10], 3'b100};
            best_idx_reg <= '0;
            best_d_reg   <= DIST_MAX;
            res_word_reg <= (action == ACT_LOAD) ? load_word : 32'd0;
        end
        else if (dist_beat.live && (dist_beat.sq_dist < best_d_reg))
        begin
            best_idx_reg <= dist_beat.idx;
            best_d_reg   <= dist_beat.sq_dist;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            best_index_reg  <= best_idx_reg;
            packed_word_reg <= res_word_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_index  = best_index_reg;
    assign packed_word = packed_word_reg;

    // a result never points past the palette
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(best_index) < PALETTE_ENTRIES))
        else $error("best_index beyond palette");

    // a result carries either an index or a packed word, not both
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((best_index == 8'd0) || (packed_word == 32'd0)))
        else $error("load and query fields both set");

    // distance beats appear only while a query runs
    a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        dist_beat.live |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance beat outside scan");

    // a load reaches the done state in the cycle after accept
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_LOAD)) |=> (state_reg == ST_DONE))
        else $error("load did not finish");

endmodule

/* tb/sv/nearest_palette_color_match_test.sv */
// self-checking testbench for the nearest palette color match block
module nearest_palette_color_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int ENTRIES         = PALETTE_ENTRIES_DEF;
    localparam int RANDOM_BEATS    = 580;
    localparam int HOLD_OFF_AT     = 200;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int IDLE_LIMIT      = 20000;
    localparam int DRAIN_CYCLES    = ENTRIES + 20;

    // one input beat and one result beat
    typedef struct {
        logic        action;
        logic [7:0]  entry;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] color;
    } palette_beat_t;

    typedef struct {
        logic [7:0]  best;
        logic [31:0] word;
    } match_result_t;

    // directed stimulus row, with a typed-in result where it is obvious
    typedef struct {
        palette_beat_t beat;
        bit            fixed;
        match_result_t res;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  entry_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [14:0] color_555;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  best_index;
    logic [31:0] packed_word;

    // palette copy and results still owed by the block
    logic [23:0]     palette_model [ENTRIES];
    match_result_t   pending_matches [$];
    directed_row_t   directed_rows [$];
    int              mismatch_count = 0;
    int              beats_taken = 0;

    nearest_palette_color_match #(
        .PALETTE_ENTRIES(ENTRIES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .entry_index(entry_index),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .color_555  (color_555),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_index (best_index),
        .packed_word(packed_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // squared gap of one channel
    function automatic logic [DIST_W-1:0] chan_gap_sq(logic [7:0] a, logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? a - b : b - a;
        return DIST_W'(d) * DIST_W'(d);
    endfunction

    // apply one beat to the palette copy and return the result it causes
    function automatic match_result_t apply_palette_beat(palette_beat_t b);
        match_result_t     r;
        logic [23:0]       rgb;
        logic [7:0]        qr;
        logic [7:0]        qg;
        logic [7:0]        qb;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best_d;
        r.best = '0;
        r.word = '0;
        if (b.action == ACT_LOAD)
        begin
            rgb    = {b.blue, b.green, b.red};
            r.word = {ALPHA_OPAQUE, rgb};
            // transparent entry stores and reports zero
            if (b.entry == TRANSPARENT_ENTRY)
            begin
                rgb    = '0;
                r.word = '0;
            end
            if (int'(b.entry) < ENTRIES)
                palette_model[b.entry] = rgb;
        end
        else
        begin
            qr     = {b.color[4:0], 3'b100};
            qg     = {b.color[9:5], 3'b100};
            qb     = {b.color[14:10], 3'b100};
            best_d = DIST_MAX;
            // strict compare keeps the lowest index on ties
            for (int v = 0; v < ENTRIES; v++)
            begin
                d = chan_gap_sq(qr, palette_model[v][7:0])
                  + chan_gap_sq(qg, palette_model[v][15:8])
                  + chan_gap_sq(qb, palette_model[v][23:16]);
                if (d < best_d)
                begin
                    best_d = d;
                    r.best = 8'(v);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(logic act, logic [7:0] entry, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [14:0] color, bit fixed,
                           logic [7:0] best, logic [31:0] word);
        directed_row_t row;
        row.beat.action = act;
        row.beat.entry  = entry;
        row.beat.red    = r;
        row.beat.green  = g;
        row.beat.blue   = b;
        row.beat.color  = color;
        row.fixed       = fixed;
        row.res.best    = best;
        row.res.word    = word;
        directed_rows.push_back(row);
    endtask

    // result check against the oldest owed result
    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_matches.size() == 0)
                report_mismatch("result beat with nothing owed, packed_word", packed_word,
                                32'd0);
            else
            begin
                want = pending_matches.pop_front();
                if (best_index !== want.best)
                    report_mismatch("best_index", 32'(best_index), 32'(want.best));
                if (packed_word !== want.word)
                    report_mismatch("packed_word", packed_word, want.word);
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0)
                || (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            repeat (seg)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'($urandom_range(0, 1));
                endcase
            end
            // block fills up while the sender keeps offering
            if (!held && beats_taken >= HOLD_OFF_AT)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held = 1'b1;
            end
        end
    end

    // reset, sender and end of run
    initial
    begin
        palette_beat_t beat;
        match_result_t pred;
        logic [23:0]   known;
        int            burst_left;
        int            gap;
        int            total;
        bit            fixed;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        action      <= ACT_LOAD;
        entry_index <= '0;
        red_in      <= '0;
        green_in    <= '0;
        blue_in     <= '0;
        color_555   <= '0;
        for (int i = 0; i < ENTRIES; i++)
            palette_model[i] = '0;

        // queries on the cleared palette, extremes, transparent entry
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h0000, 1, 8'h00, 32'h0);
        add_row(ACT_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 1, 8'h00, 32'h0);
        add_row(ACT_LOAD,  8'h00, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 1, 8'h00, 32'hFFFF_FFFF);
        add_row(ACT_LOAD,  8'hFF, 8'h12, 8'h34, 8'h56, 15'h0000, 1, 8'h00, 32'h0);
        add_row(ACT_LOAD,  8'h01, 8'h00, 8'h00, 8'h00, 15'h0000, 1, 8'h00, 32'hFF00_0000);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h0000, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7FFF, 0, '0, '0);
        // pure channels
        add_row(ACT_LOAD,  8'h03, 8'hF8, 8'h00, 8'h00, 15'h0000, 0, '0, '0);
        add_row(ACT_LOAD,  8'h04, 8'h00, 8'hF8, 8'h00, 15'h0000, 0, '0, '0);
        add_row(ACT_LOAD,  8'h05, 8'h00, 8'h00, 8'hF8, 15'h0000, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h001F, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h03E0, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7C00, 0, '0, '0);
        // tie between two equal entries, lower index wins
        add_row(ACT_LOAD,  8'h15, 8'h64, 8'h64, 8'h64, 15'h0000, 0, '0, '0);
        add_row(ACT_LOAD,  8'h14, 8'h64, 8'h64, 8'h64, 15'h0000, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h318C, 0, '0, '0);
        // transparent entry stays black
        add_row(ACT_LOAD,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 1, 8'h00, 32'h0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7FFF, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h5555, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h2AAA, 0, '0, '0);
        // overwrite of entry zero
        add_row(ACT_LOAD,  8'h00, 8'h00, 8'h00, 8'h00, 15'h0000, 1, 8'h00, 32'hFF00_0000);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7FFF, 0, '0, '0);
        add_row(ACT_LOAD,  8'h80, 8'hAA, 8'h55, 8'hAA, 15'h5555, 0, '0, '0);
        add_row(ACT_LOAD,  8'h7F, 8'h55, 8'hAA, 8'h55, 15'h2AAA, 0, '0, '0);
        add_row(ACT_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h2955, 0, '0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        total      = directed_rows.size() + RANDOM_BEATS;
        burst_left = 0;
        for (int k = 0; k < total; k++)
        begin
            fixed = 1'b0;
            if (k < directed_rows.size())
            begin
                beat  = directed_rows[k].beat;
                fixed = directed_rows[k].fixed;
            end
            else
            begin
                beat.action = ($urandom_range(0, 99) < 55) ? ACT_LOAD : ACT_QUERY;
                beat.entry  = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                    beat.entry = 8'($urandom_range(0, 15));
                if ($urandom_range(0, 15) == 0)
                    beat.entry = TRANSPARENT_ENTRY;
                beat.red   = 8'($urandom);
                beat.green = 8'($urandom);
                beat.blue  = 8'($urandom);
                beat.color = 15'($urandom);
                // some loads on the query grid, so exact hits and ties occur
                if (beat.action == ACT_LOAD && $urandom_range(0, 3) == 0)
                begin
                    beat.red   = {beat.red[7:3], 3'b100};
                    beat.green = {beat.green[7:3], 3'b100};
                    beat.blue  = {beat.blue[7:3], 3'b100};
                end
                // some queries aimed at an entry already in the palette
                if (beat.action == ACT_QUERY && $urandom_range(0, 2) == 0)
                begin
                    known      = palette_model[8'($urandom_range(0, ENTRIES - 1))];
                    beat.color = {known[23:19], known[15:11], known[7:3]};
                end
            end

            // bursts with random gaps between them
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;

            in_valid    <= 1'b1;
            action      <= beat.action;
            entry_index <= beat.entry;
            red_in      <= beat.red;
            green_in    <= beat.green;
            blue_in     <= beat.blue;
            color_555   <= beat.color;
            @(posedge clk);
            while (in_stall !== 1'b0)
                @(posedge clk);

            pred = apply_palette_beat(beat);
            if (fixed)
                pending_matches.push_back(directed_rows[k].res);
            else
                pending_matches.push_back(pred);
            beats_taken++;
        end
        in_valid <= 1'b0;

        // drain, then let any stray result show up
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/npc_pkg.sv
rtl/npc_dist_unit.sv
rtl/nearest_palette_color_match.sv
tb/sv/nearest_palette_color_match_test.sv
